// ===== sv/pic_pkg.sv =====
// Shared types and constants of the point in circle or mesh hit test.
// No dependencies; the queue, front, back and top level use this package.
package pic_pkg;

  localparam int COORD_BITS_DEF = 32;
  localparam int QUEUE_DEPTH    = 2;
  // floor((vx*cos - vy*sin) / 2^14) of 32-bit by 16-bit products
  localparam int ROT_W          = 35;

  localparam logic CMD_CIRCLE = 1'b0;
  localparam logic CMD_MESH   = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic        [30:0] scale;
    logic signed [15:0] cs;
    logic signed [15:0] sn;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               last;
    logic               near;   // both circle distances below 2^31
    logic        [30:0] dx;
    logic        [30:0] dy;
  } item_t;

endpackage

// ===== sv/pic_mul.sv =====
// Iterative signed multiplier, one 16-bit digit of |b| per cycle.
// Depends on nothing but its OPW parameter.
module pic_mul #(
  parameter int OPW = 36
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [OPW-1:0]   a,
  input  logic signed [OPW-1:0]   b,
  output logic                    done,
  output logic signed [2*OPW-1:0] p
);

  localparam int ND = (OPW + 15) / 16;
  localparam int DW = 16 * ND;
  localparam int AW = OPW + DW;
  localparam int PW = 2 * OPW;
  localparam int CW = $clog2(ND);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

  mstate_t              state_r;
  logic [OPW-1:0]       ma_r;
  logic [DW-1:0]        mb_r;
  logic                 neg_r;
  logic [CW-1:0]        cnt_r;
  logic [AW-1:0]        acc_r;
  logic signed [PW-1:0] p_r;
  logic                 done_r;

  logic [OPW-1:0]  ma_w;
  logic [OPW-1:0]  mb_w;
  logic [15:0]     digit;
  logic [OPW+15:0] part;
  logic [AW-1:0]   addend;

  assign ma_w   = a[OPW-1] ? unsigned'(-a) : unsigned'(a);
  assign mb_w   = b[OPW-1] ? unsigned'(-b) : unsigned'(b);
  assign digit  = mb_r[{cnt_r, 4'b0000} +: 16];
  assign part   = ma_r * digit;
  assign addend = AW'(part) << {cnt_r, 4'b0000};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        M_IDLE: begin
          if (start) begin
            ma_r    <= ma_w;
            mb_r    <= DW'(mb_w);
            neg_r   <= a[OPW-1] ^ b[OPW-1];
            acc_r   <= '0;
            cnt_r   <= '0;
            state_r <= M_RUN;
          end
        end
        M_RUN: begin
          acc_r <= acc_r + addend;
          if (cnt_r == CW'(ND - 1)) begin
            state_r <= M_FIN;
          end else begin
            cnt_r <= cnt_r + CW'(1);
          end
        end
        M_FIN: begin
          p_r     <= neg_r ? -$signed(PW'(acc_r)) : $signed(PW'(acc_r));
          done_r  <= 1'b1;
          state_r <= M_IDLE;
        end
        default: state_r <= M_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign p    = p_r;

endmodule

// ===== sv/pic_fifo.sv =====
// Short item queue between the front and back parts.
// Depends on pic_pkg for the item type.
module pic_fifo #(
  parameter int DEPTH = pic_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pic_pkg::item_t wr_item,
  output logic           full,
  input  logic           pop,
  output pic_pkg::item_t rd_item,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pic_pkg::item_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r;
  logic [PTR_W-1:0] rp_r;
  logic [CNT_W-1:0] cnt_r;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_item = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== sv/pic_front.sv =====
// Input side: takes transfers, forms circle distances, pushes the queue.
// Depends on pic_pkg for the item type.
module pic_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic        [30:0] in_scale,
  input  logic signed [15:0] in_cosine,
  input  logic signed [15:0] in_sine,
  input  logic signed [31:0] in_vertex_x,
  input  logic signed [31:0] in_vertex_y,
  input  logic               in_last_vertex,
  input  logic               q_full,
  output logic               q_push,
  output pic_pkg::item_t     q_item
);

  logic signed [32:0] dxs;
  logic signed [32:0] dys;
  logic        [32:0] dxm;
  logic        [32:0] dym;

  assign dxs = 33'(in_point_x) - 33'(in_center_x);
  assign dys = 33'(in_point_y) - 33'(in_center_y);
  assign dxm = dxs[32] ? unsigned'(-dxs) : unsigned'(dxs);
  assign dym = dys[32] ? unsigned'(-dys) : unsigned'(dys);

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.cmd   = in_cmd;
    q_item.px    = in_point_x;
    q_item.py    = in_point_y;
    q_item.cx    = in_center_x;
    q_item.cy    = in_center_y;
    q_item.scale = in_scale;
    q_item.cs    = in_cosine;
    q_item.sn    = in_sine;
    q_item.vx    = in_vertex_x;
    q_item.vy    = in_vertex_y;
    q_item.last  = in_last_vertex;
    q_item.near  = !dxm[32] && !dxm[31] && !dym[32] && !dym[31];
    q_item.dx    = dxm[30:0];
    q_item.dy    = dym[30:0];
  end

endmodule

// ===== sv/pic_back.sv =====
// Back part: sequences transform, triangle and circle products on pic_mul.
// Depends on pic_pkg and pic_mul.
module pic_back #(
  parameter int COORD_BITS = pic_pkg::COORD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  pic_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic           out_hit
);

  localparam int CB  = COORD_BITS;
  localparam int OPW = (CB + 1 > 36) ? CB + 1 : 36;
  localparam int PW  = 2 * OPW;
  localparam int RW  = pic_pkg::ROT_W;
  localparam logic signed [PW-1:0] HI_W = PW'((64'sd1 <<< (CB - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] LO_W = ~HI_W;

  typedef enum logic [3:0] {
    B_IDLE, B_ISSUE, B_WAIT, B_ROT, B_XF, B_T1, B_T2, B_CIR, B_FIN
  } bstate_t;

  typedef enum logic [4:0] {
    K_RX0, K_RX1, K_RY0, K_RY1, K_SX, K_SY,
    K_A0, K_A1, K_A2, K_A3, K_B0, K_B1, K_B2, K_B3,
    K_C0, K_C1, K_C2
  } step_t;

  bstate_t              state_r;
  step_t                step_r;
  pic_pkg::item_t       it_r;
  logic signed [PW-1:0] prod_r [4];
  logic signed [RW-1:0] rx_r;
  logic signed [RW-1:0] ry_r;
  logic signed [CB-1:0] tx_r;
  logic signed [CB-1:0] ty_r;
  logic signed [CB-1:0] c_r [4];
  logic [1:0]           cnt_r;
  logic                 seen_r;
  logic                 pass1_r;
  logic                 cir_r;
  logic                 out_valid_r;
  logic                 out_hit_r;

  logic signed [OPW-1:0] op_a;
  logic signed [OPW-1:0] op_b;
  logic                  mul_done;
  logic signed [PW-1:0]  mul_p;
  logic [1:0]            pidx;

  function automatic logic signed [CB-1:0] sat_c(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] r;
    r = (v > HI_W) ? HI_W : ((v < LO_W) ? LO_W : v);
    return r[CB-1:0];
  endfunction

  // extended corners, point and new vertex
  logic signed [OPW-1:0] x0, y0, x1, y1, xt, yt, xp, yp;
  assign x0 = OPW'(c_r[0]);
  assign y0 = OPW'(c_r[1]);
  assign x1 = OPW'(c_r[2]);
  assign y1 = OPW'(c_r[3]);
  assign xt = OPW'(tx_r);
  assign yt = OPW'(ty_r);
  assign xp = OPW'($signed(it_r.px));
  assign yp = OPW'($signed(it_r.py));

  logic [RW-1:0] mrx, mry;
  assign mrx = rx_r[RW-1] ? unsigned'(-rx_r) : unsigned'(rx_r);
  assign mry = ry_r[RW-1] ? unsigned'(-ry_r) : unsigned'(ry_r);

  always_comb begin
    op_a = '0;
    op_b = '0;
    pidx = 2'd0;
    unique case (step_r)
      K_RX0: begin op_a = OPW'($signed(it_r.vx)); op_b = OPW'($signed(it_r.cs)); pidx = 2'd0; end
      K_RX1: begin op_a = OPW'($signed(it_r.vy)); op_b = OPW'($signed(it_r.sn)); pidx = 2'd1; end
      K_RY0: begin op_a = OPW'($signed(it_r.vx)); op_b = OPW'($signed(it_r.sn)); pidx = 2'd2; end
      K_RY1: begin op_a = OPW'($signed(it_r.vy)); op_b = OPW'($signed(it_r.cs)); pidx = 2'd3; end
      K_SX: begin op_a = $signed(OPW'(mrx)); op_b = $signed(OPW'(it_r.scale)); pidx = 2'd0; end
      K_SY: begin op_a = $signed(OPW'(mry)); op_b = $signed(OPW'(it_r.scale)); pidx = 2'd1; end
      // corner at the second stored vertex, arms to first vertex and new one
      K_A0: begin op_a = x0 - x1; op_b = yp - y1; pidx = 2'd0; end
      K_A1: begin op_a = y0 - y1; op_b = xp - x1; pidx = 2'd1; end
      K_A2: begin op_a = xt - x1; op_b = yp - y1; pidx = 2'd2; end
      K_A3: begin op_a = yt - y1; op_b = xp - x1; pidx = 2'd3; end
      // corner at the new vertex, arms to both stored vertices
      K_B0: begin op_a = x0 - xt; op_b = yp - yt; pidx = 2'd0; end
      K_B1: begin op_a = y0 - yt; op_b = xp - xt; pidx = 2'd1; end
      K_B2: begin op_a = x1 - xt; op_b = yp - yt; pidx = 2'd2; end
      K_B3: begin op_a = y1 - yt; op_b = xp - xt; pidx = 2'd3; end
      K_C0: begin op_a = $signed(OPW'(it_r.dx)); op_b = $signed(OPW'(it_r.dx)); pidx = 2'd0; end
      K_C1: begin op_a = $signed(OPW'(it_r.dy)); op_b = $signed(OPW'(it_r.dy)); pidx = 2'd1; end
      K_C2: begin
        op_a = $signed(OPW'(it_r.scale));
        op_b = $signed(OPW'(it_r.scale));
        pidx = 2'd2;
      end
      default: begin op_a = '0; op_b = '0; pidx = 2'd0; end
    endcase
  end

  pic_mul #(.OPW(OPW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == B_ISSUE),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // rotation: floor shift by 14
  logic signed [PW-1:0] sumx, sumy, shx, shy;
  assign sumx = prod_r[0] - prod_r[1];
  assign sumy = prod_r[2] + prod_r[3];
  assign shx  = sumx >>> 14;
  assign shy  = sumy >>> 14;

  // scale is truncated toward zero on the magnitude, then offset
  logic signed [PW-1:0] smx, smy, svx, svy;
  logic signed [CB-1:0] ssx, ssy, tx_w, ty_w;
  assign smx  = prod_r[0] >>> 16;
  assign smy  = prod_r[1] >>> 16;
  assign svx  = rx_r[RW-1] ? -smx : smx;
  assign svy  = ry_r[RW-1] ? -smy : smy;
  assign ssx  = sat_c(svx);
  assign ssy  = sat_c(svy);
  assign tx_w = sat_c(PW'(ssx) + PW'($signed(it_r.cx)));
  assign ty_w = sat_c(PW'(ssy) + PW'($signed(it_r.cy)));

  logic gt_a, lt_a, gt_b, lt_b, pass_w, cir_w;
  assign gt_a   = prod_r[0] > prod_r[1];
  assign lt_a   = prod_r[0] < prod_r[1];
  assign gt_b   = prod_r[2] > prod_r[3];
  assign lt_b   = prod_r[2] < prod_r[3];
  assign pass_w = (gt_a && lt_b) || (lt_a && gt_b);
  assign cir_w  = it_r.near && ((prod_r[0] + prod_r[1]) < prod_r[2]);

  assign q_pop = (state_r == B_IDLE) && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      step_r      <= K_RX0;
      cnt_r       <= 2'd0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        c_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (!q_empty) begin
            it_r    <= q_item;
            step_r  <= (q_item.cmd == pic_pkg::CMD_CIRCLE) ? K_C0 : K_RX0;
            state_r <= B_ISSUE;
          end
        end
        B_ISSUE: state_r <= B_WAIT;
        B_WAIT: begin
          if (mul_done) begin
            prod_r[pidx] <= mul_p;
            case (step_r)
              K_RY1:   state_r <= B_ROT;
              K_SY:    state_r <= B_XF;
              K_A3:    state_r <= B_T1;
              K_B3:    state_r <= B_T2;
              K_C2:    state_r <= B_CIR;
              default: begin
                step_r  <= step_t'(step_r + 5'd1);
                state_r <= B_ISSUE;
              end
            endcase
          end
        end
        B_ROT: begin
          rx_r    <= shx[RW-1:0];
          ry_r    <= shy[RW-1:0];
          step_r  <= K_SX;
          state_r <= B_ISSUE;
        end
        B_XF: begin
          tx_r <= tx_w;
          ty_r <= ty_w;
          if (cnt_r == 2'd2) begin
            step_r  <= K_A0;
            state_r <= B_ISSUE;
          end else begin
            if (cnt_r == 2'd0) begin
              c_r[0] <= tx_w;
              c_r[1] <= ty_w;
            end else begin
              c_r[2] <= tx_w;
              c_r[3] <= ty_w;
            end
            cnt_r   <= cnt_r + 2'd1;
            state_r <= B_FIN;
          end
        end
        B_T1: begin
          pass1_r <= pass_w;
          step_r  <= K_B0;
          state_r <= B_ISSUE;
        end
        B_T2: begin
          if (pass1_r && pass_w) begin
            seen_r <= 1'b1;
          end
          cnt_r   <= 2'd0;
          state_r <= B_FIN;
        end
        B_CIR: begin
          cir_r   <= cir_w;
          state_r <= B_FIN;
        end
        B_FIN: begin
          // results wait here until the output register has drained
          if (it_r.cmd == pic_pkg::CMD_CIRCLE) begin
            if (!out_valid_r) begin
              out_valid_r <= 1'b1;
              out_hit_r   <= cir_r;
              state_r     <= B_IDLE;
            end
          end else if (it_r.last) begin
            if (!out_valid_r) begin
              out_valid_r <= 1'b1;
              out_hit_r   <= seen_r;
              seen_r      <= 1'b0;
              cnt_r       <= 2'd0;
              state_r     <= B_IDLE;
            end
          end else begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

// ===== sv/point_in_circle_or_mesh_test.sv =====
// Point in circle or mesh hit test, top level.
// Depends on pic_pkg, pic_front, pic_fifo and pic_back.
//
// Input channel in_*: one transfer per item. cmd 0 tests the point against a
// circle (center, radius in scale) and gives one hit result. cmd 1 carries one
// mesh vertex; every third vertex closes a triangle, hits are sticky, and the
// vertex flagged last_vertex gives the single mesh result.
// Output channel out_*: one hit bit per result, held in an output register.
// All products run on one iterative multiplier, which holds the back end while
// it forms each product from ND 16-bit digits, ND = ceil(max(36, COORD_BITS+1)
// / 16). A circle item needs the fewest products, a vertex that closes a
// triangle the most.
// Items are worked one at a time; a two-entry queue keeps taking transfers
// while the back end is busy or a result waits.
// Reset clears the queue, the corner count, the sticky hit and out_valid.
// A stalled result holds; the back end waits for the output register to empty
// before writing the next result, and in_stall rises once the queue is full.
module point_in_circle_or_mesh_test #(
  parameter int COORD_BITS = pic_pkg::COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_center_x,
  input  logic signed [31:0] in_center_y,
  input  logic        [30:0] in_scale,
  input  logic signed [15:0] in_cosine,
  input  logic signed [15:0] in_sine,
  input  logic signed [31:0] in_vertex_x,
  input  logic signed [31:0] in_vertex_y,
  input  logic               in_last_vertex,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  pic_pkg::item_t q_wr;
  pic_pkg::item_t q_rd;

  pic_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_point_x     (in_point_x),
    .in_point_y     (in_point_y),
    .in_center_x    (in_center_x),
    .in_center_y    (in_center_y),
    .in_scale       (in_scale),
    .in_cosine      (in_cosine),
    .in_sine        (in_sine),
    .in_vertex_x    (in_vertex_x),
    .in_vertex_y    (in_vertex_y),
    .in_last_vertex (in_last_vertex),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_item         (q_wr)
  );

  pic_fifo #(.DEPTH(pic_pkg::QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (q_rd),
    .empty   (q_empty)
  );

  pic_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_hit   (out_hit)
  );

endmodule

// ===== sv/pic_checker.sv =====
// Port-level checks of the hit test, bound to the top level.
// Depends only on the top level's port names.
module pic_assert (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_hit
);

  // reset leaves an empty queue and no pending result
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("output valid or input stall after reset");

  // a new result is only written into an empty output register
  a_no_refill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("result written in the cycle of an output transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_hit))
    else $error("stalled result changed");

  // the queue only fills after an input transfer
  a_stall_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid))
    else $error("input stall rose without an input transfer");

endmodule

bind point_in_circle_or_mesh_test pic_assert u_pic_assert (.*);
